### rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the cursor text buffer: command codes, cell
// operations and the control bundle broadcast to the row of character cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

   // Position width covers a length of up to 64 bytes
   localparam int POS_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int DEPTH_DEF = 64;

   typedef enum logic [2:0] {
      KIND_INSERT    = 3'd0,
      KIND_MOVE      = 3'd1,
      KIND_BACKSPACE = 3'd2,
      KIND_DELETE    = 3'd3,
      KIND_PRINT     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CELL_CMD_HOLD,
      CELL_CMD_INSERT,
      CELL_CMD_REMOVE,
      CELL_CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type            cmd;
      logic [POS_W-1:0]        pos;
      logic [POS_W-1:0]        len;
      logic [CHAR_W-1:0]       char_value;
   } cell_ctrl_type;

endpackage : ctb_pkg

`default_nettype wire

### rtl/core/cursor_text_buffer_unit.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer_unit
// Line-editing byte buffer with a cursor, built as a row of character cells.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command per beat: insert a byte at the
//   cursor, move the cursor by a signed offset (clamped to 0..length),
//   backspace, delete, or print. Edit commands complete in the cycle of
//   acceptance, so they run back to back at one beat per cycle.
//   Print streams the text on the rsp_ channel one byte per beat, starting
//   at the first byte, with rsp_last_char on the final beat. An empty buffer
//   gives one beat with rsp_text_empty set and a zero byte.
//   A print holds req_stall high until its final beat is taken, also while
//   the receiver stalls, so the next command is taken only after the run;
//   each taken beat rotates the cell row by one place, so the text is back
//   in order after the run. The first rsp_ beat appears the cycle after the
//   print is accepted.
//   While a print is running req_stall is high. rsp_stall holds the current
//   byte and freezes the row.
//   Reset clears length, cursor and the print state; cell contents are not
//   cleared and are only ever read below the length.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_text_buffer_unit
   import ctb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_kind,
   input  wire logic [CHAR_W-1:0]     req_char_value,
   input  wire logic signed [7:0]     req_move_offset,
   // text channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [CHAR_W-1:0]          rsp_out_char,
   output logic                       rsp_last_char,
   output logic                       rsp_text_empty
);

   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_PRINT
   } state_type;

   state_type           state_ff,  state_in;
   logic [POS_W-1:0]    length_ff, length_in;
   logic [POS_W-1:0]    cursor_ff, cursor_in;
   logic [POS_W-1:0]    remain_ff, remain_in;
   logic                empty_ff,  empty_in;

   logic                req_take;
   logic                rsp_take;
   logic                last_beat;
   logic signed [8:0]   move_sum;
   cell_ctrl_type       ctrl;

   logic [CHAR_W-1:0]   cell_data [DEPTH];

   assign req_stall = (state_ff == ST_PRINT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_PRINT);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign last_beat = empty_ff || (remain_ff == POS_W'(1));

   assign move_sum = $signed({2'b00, cursor_ff})
                   + $signed({req_move_offset[7], req_move_offset});

   // Command decode: update length, cursor and the print run, and broadcast
   // the cell operation for this cycle
   always_comb begin
      state_in        = state_ff;
      length_in       = length_ff;
      cursor_in       = cursor_ff;
      remain_in       = remain_ff;
      empty_in        = empty_ff;
      ctrl.cmd        = CELL_CMD_HOLD;
      ctrl.pos        = cursor_ff;
      ctrl.len        = length_ff;
      ctrl.char_value = req_char_value;

      if (req_take) begin
         case (req_kind)
            KIND_INSERT: begin
               // drop the byte when the row is full
               if (length_ff < DEPTH_POS) begin
                  ctrl.cmd  = CELL_CMD_INSERT;
                  length_in = length_ff + POS_W'(1);
                  cursor_in = cursor_ff + POS_W'(1);
               end
            end
            KIND_MOVE: begin
               if (move_sum > $signed({2'b00, length_ff})) begin
                  cursor_in = length_ff;
               end else if (move_sum < 0) begin
                  cursor_in = '0;
               end else begin
                  cursor_in = move_sum[POS_W-1:0];
               end
            end
            KIND_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  ctrl.cmd  = CELL_CMD_REMOVE;
                  ctrl.pos  = cursor_ff - POS_W'(1);
                  length_in = length_ff - POS_W'(1);
                  cursor_in = cursor_ff - POS_W'(1);
               end
            end
            KIND_DELETE: begin
               if (cursor_ff < length_ff) begin
                  ctrl.cmd  = CELL_CMD_REMOVE;
                  length_in = length_ff - POS_W'(1);
               end
            end
            KIND_PRINT: begin
               state_in  = ST_PRINT;
               remain_in = length_ff;
               empty_in  = (length_ff == '0);
            end
            default: begin
               // unused command codes are ignored
               state_in = ST_IDLE;
            end
         endcase
      end else if (rsp_take) begin
         // advance the row by one byte per taken beat
         if (!empty_ff) begin
            ctrl.cmd = CELL_CMD_ROTATE;
         end
         remain_in = remain_ff - POS_W'(1);
         if (last_beat) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= '0;
         cursor_ff <= '0;
         remain_ff <= '0;
         empty_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         length_ff <= length_in;
         cursor_ff <= cursor_in;
         remain_ff <= remain_in;
         empty_ff  <= empty_in;
      end
   end

   // Row of character cells; the ends see their own byte as the missing
   // neighbour, and every cell sees cell 0 for the rotation wrap
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [CHAR_W-1:0] left_byte;
      logic [CHAR_W-1:0] right_byte;

      if (gi == 0) begin : g_first
         assign left_byte = cell_data[gi];
      end else begin : g_mid_left
         assign left_byte = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_byte = cell_data[gi];
      end else begin : g_mid_right
         assign right_byte = cell_data[gi+1];
      end

      ctb_cell #(
         .INDEX      (gi)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_byte),
         .right_data (right_byte),
         .wrap_data  (cell_data[0]),
         .data_out   (cell_data[gi])
      );
   end

   // Head of the row is the byte on the wire
   assign rsp_out_char   = empty_ff ? '0 : cell_data[0];
   assign rsp_last_char  = last_beat;
   assign rsp_text_empty = empty_ff;

`ifndef SYNTHESIS
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond end of text");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      length_ff <= DEPTH_POS)
      else $error("text length exceeds buffer depth");

   a_stall_holds_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(remain_ff))
      else $error("print run moved while stalled");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_empty |-> rsp_last_char)
      else $error("empty print beat not marked last");

   a_edit_no_output: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_kind != KIND_PRINT) |=> !rsp_valid)
      else $error("edit command produced a text beat");
`endif

endmodule : cursor_text_buffer_unit

`default_nettype wire

### rtl/core/ctb_cell.sv
// ----------------------------------------------------------------------------
// ctb_cell
// One character cell of the buffer row. Decides from its own place and the
// broadcast control whether to hold, take a neighbour's or cell 0's byte, or load a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_cell
   import ctb_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic                clock,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [CHAR_W-1:0]   left_data,
   input  wire logic [CHAR_W-1:0]   right_data,
   input  wire logic [CHAR_W-1:0]   wrap_data,
   output logic      [CHAR_W-1:0]   data_out
);

   localparam logic [POS_W-1:0] MY_POS  = POS_W'(INDEX);
   localparam logic [POS_W-1:0] MY_NEXT = POS_W'(INDEX + 1);

   logic [CHAR_W-1:0] data_ff;
   logic [CHAR_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CELL_CMD_INSERT: begin
            // open a gap at the cursor: everything above moves up one place
            if (MY_POS > ctrl.pos) begin
               data_in = left_data;
            end else if (MY_POS == ctrl.pos) begin
               data_in = ctrl.char_value;
            end
         end
         CELL_CMD_REMOVE: begin
            if (MY_POS >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         CELL_CMD_ROTATE: begin
            // rotate the used part of the row left by one byte
            if (MY_NEXT < ctrl.len) begin
               data_in = right_data;
            end else if (MY_NEXT == ctrl.len) begin
               data_in = wrap_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule : ctb_cell

`default_nettype wire
